// ----- rtl/g711_companding_codec_defines.svh -----
// ----------------------------------------------------------------------------
// G.711 codec assertion macros
// Shared property wrappers for the codec's assertions, clocked on clk.
// ----------------------------------------------------------------------------
`ifndef G711_COMPANDING_CODEC_DEFINES_SVH
`define G711_COMPANDING_CODEC_DEFINES_SVH

// Check a property outside reset.
`define G711_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a property at every edge, reset included.
`define G711_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- rtl/g711cc_pkg.sv -----
// ----------------------------------------------------------------------------
// G.711 codec package
// Codes, constants and segment helpers shared by the codec files.
// ----------------------------------------------------------------------------
`default_nettype none

package g711cc_pkg;

  typedef enum logic {
    MODE_ENCODE = 1'b0,
    MODE_DECODE = 1'b1
  } mode_t;

  typedef enum logic {
    LAW_A  = 1'b0,
    LAW_MU = 1'b1
  } law_t;

  localparam logic [7:0]  A_INV_POS   = 8'hD5;
  localparam logic [7:0]  A_INV_NEG   = 8'h55;
  localparam logic [7:0]  A_XOR       = 8'h55;
  localparam logic [7:0]  MU_INV_POS  = 8'hFF;
  localparam logic [7:0]  MU_INV_NEG  = 8'h7F;
  localparam logic [7:0]  CODE_MAX    = 8'h7F;
  localparam logic [13:0] MU_CLIP     = 14'd8159;
  localparam logic [13:0] MU_BIAS     = 14'd33;
  localparam logic [8:0]  A_DEC_OFFS  = 9'h108;
  localparam logic [8:0]  MU_DEC_BIAS = 9'h084;
  localparam logic [3:0]  MU_SEG_OVER = 4'd8;

  // Index of the highest set bit, zero for a zero word.
  function automatic logic [3:0] msb_index(input logic [13:0] v);
    logic [3:0] idx;
    idx = 4'd0;
    for (int i = 1; i < 14; i++) begin
      if (v[i]) idx = 4'(i);
    end
    return idx;
  endfunction

  // A-law segment: 0 up to 0x1F, then one per extra magnitude bit.
  function automatic logic [2:0] a_segment(input logic [11:0] v);
    logic [3:0] m;
    m = msb_index({2'b00, v});
    return (m < 4'd5) ? 3'd0 : 3'(m - 4'd4);
  endfunction

  // Mu-law segment: 0 up to 0x3F, 8 means beyond the last segment.
  function automatic logic [3:0] mu_segment(input logic [13:0] v);
    logic [3:0] m;
    m = msb_index(v);
    return (m < 4'd6) ? 4'd0 : (m - 4'd5);
  endfunction

endpackage

`default_nettype wire

// ----- rtl/g711cc_if.sv -----
// ----------------------------------------------------------------------------
// G.711 codec channels
// Valid/ready request channels for the sample input and the result output.
// ----------------------------------------------------------------------------
`default_nettype none

interface g711cc_in_if import g711cc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               mode;
  logic signed [15:0] pcm_in;
  logic        [7:0]  code_in;

  modport source (output valid, mode, pcm_in, code_in, input ready);
  modport sink   (input valid, mode, pcm_in, code_in, output ready);
endinterface

interface g711cc_out_if import g711cc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic        [7:0]  code_out;
  logic signed [15:0] pcm_out;

  modport source (output valid, code_out, pcm_out, input ready);
  modport sink   (input valid, code_out, pcm_out, output ready);
endinterface

`default_nettype wire

// ----- rtl/g711_companding_codec.sv -----
// ----------------------------------------------------------------------------
// G.711 companding codec
// Stateless A-law / mu-law encoder and decoder, three-stage pipeline.
// ----------------------------------------------------------------------------
//
//   channel   direction  payload                       request accepted when
//   in_ch     sink       mode, pcm_in[15:0], code_in   valid && ready
//   out_ch    source     code_out[7:0], pcm_out[15:0]  valid && ready
//   cfg_*     sink       cfg_wdata (law_select)        cfg_we
//
// One request per cycle sustained while out_ch does not stall; stage 1 loads
// on the edge that accepts a request, then stage 2, then the output register.
// The three stages advance together: in_ch.ready is high whenever the output
// register is empty or being drained, so a stall at out_ch holds every stage.
// Synchronous active-low reset clears the valid bits and selects A-law.
// Write cfg_* only when no request is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

`include "g711_companding_codec_defines.svh"

module g711_companding_codec import g711cc_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    cfg_we,
  input  wire logic    cfg_wdata,
  g711cc_in_if.sink    in_ch,
  g711cc_out_if.source out_ch
);

  // Law select register
  law_t law_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      law_r <= LAW_A;
    end else if (cfg_we) begin
      law_r <= law_t'(cfg_wdata);
    end
  end

  // Pipeline advance: every stage moves when the output slot frees up.
  logic out_valid_r;
  logic adv;

  assign adv         = !out_valid_r || out_ch.ready;
  assign in_ch.ready = adv;

  // ------------------------------------------------------------------------
  // Stage 1: fold the sample to a magnitude, strip the transmission mask
  // from the code byte.
  // ------------------------------------------------------------------------
  logic        s1_valid_r;
  mode_t       s1_mode_r;
  law_t        s1_law_r;
  logic        s1_neg_r;
  logic [13:0] s1_mag_r;
  logic        s1_flag_r;
  logic [2:0]  s1_seg_r;
  logic [3:0]  s1_mant_r;

  logic [13:0] s1_mag_nxt;
  logic [7:0]  s1_byte_nxt;

  always_comb begin
    if (law_r == LAW_A) begin
      // floor(s/8), negatives folded to one's complement
      s1_mag_nxt  = in_ch.pcm_in[15] ? {2'b00, ~in_ch.pcm_in[14:3]}
                                     : {2'b00,  in_ch.pcm_in[14:3]};
      s1_byte_nxt = in_ch.code_in ^ A_XOR;
    end else begin
      // floor(s/4), then true magnitude (up to 8192)
      s1_mag_nxt  = in_ch.pcm_in[15] ? (14'd0 - in_ch.pcm_in[15:2])
                                     : in_ch.pcm_in[15:2];
      s1_byte_nxt = ~in_ch.code_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_mode_r <= mode_t'(in_ch.mode);
      s1_law_r  <= law_r;
      s1_neg_r  <= in_ch.pcm_in[15];
      s1_mag_r  <= s1_mag_nxt;
      s1_flag_r <= s1_byte_nxt[7];
      s1_seg_r  <= s1_byte_nxt[6:4];
      s1_mant_r <= s1_byte_nxt[3:0];
    end
  end

  // ------------------------------------------------------------------------
  // Stage 2: clip and bias the mu-law magnitude; build the decoder's
  // unshifted value and its shift.
  // ------------------------------------------------------------------------
  logic        s2_valid_r;
  mode_t       s2_mode_r;
  law_t        s2_law_r;
  logic        s2_neg_r;
  logic [13:0] s2_val_r;
  logic        s2_flag_r;
  logic [8:0]  s2_base_r;
  logic [2:0]  s2_sh_r;

  logic [13:0] s2_val_nxt;
  logic [8:0]  s2_base_nxt;
  logic [2:0]  s2_sh_nxt;

  always_comb begin
    if (s1_law_r == LAW_A) begin
      s2_val_nxt = s1_mag_r;
      if (s1_seg_r == 3'd0) begin
        s2_base_nxt = {1'b0, s1_mant_r, 4'h8};
        s2_sh_nxt   = 3'd0;
      end else begin
        s2_base_nxt = {1'b0, s1_mant_r, 4'h0} + A_DEC_OFFS;
        s2_sh_nxt   = s1_seg_r - 3'd1;
      end
    end else begin
      // a clipped magnitude biases to 8192, past the last segment
      s2_val_nxt  = ((s1_mag_r > MU_CLIP) ? MU_CLIP : s1_mag_r) + MU_BIAS;
      s2_base_nxt = {2'b00, s1_mant_r, 3'b000} + MU_DEC_BIAS;
      s2_sh_nxt   = s1_seg_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (adv) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_mode_r <= s1_mode_r;
      s2_law_r  <= s1_law_r;
      s2_neg_r  <= s1_neg_r;
      s2_val_r  <= s2_val_nxt;
      s2_flag_r <= s1_flag_r;
      s2_base_r <= s2_base_nxt;
      s2_sh_r   <= s2_sh_nxt;
    end
  end

  // ------------------------------------------------------------------------
  // Stage 3: segment search and code assembly, decoder shift and sign;
  // lands in the output register.
  // ------------------------------------------------------------------------
  mode_t              out_mode_r;
  logic [7:0]         out_code_r;
  logic signed [15:0] out_pcm_r;

  logic [2:0]  a_seg;
  logic [3:0]  mu_seg;
  logic [13:0] a_shifted;
  logic [13:0] mu_shifted;
  logic [7:0]  enc_code;
  logic [15:0] dec_mag;
  logic [15:0] dec_pcm;
  logic [7:0]  out_code_nxt;
  logic [15:0] out_pcm_nxt;

  always_comb begin
    a_seg      = a_segment(s2_val_r[11:0]);
    mu_seg     = mu_segment(s2_val_r);
    // the two lowest segments share one step size
    a_shifted  = s2_val_r >> ((a_seg == 3'd0) ? 3'd1 : a_seg);
    mu_shifted = s2_val_r >> (mu_seg + 4'd1);

    if (s2_law_r == LAW_A) begin
      enc_code = {1'b0, a_seg, a_shifted[3:0]} ^ (s2_neg_r ? A_INV_NEG : A_INV_POS);
    end else if (mu_seg == MU_SEG_OVER) begin
      enc_code = CODE_MAX ^ (s2_neg_r ? MU_INV_NEG : MU_INV_POS);
    end else begin
      enc_code = {1'b0, mu_seg[2:0], mu_shifted[3:0]}
                 ^ (s2_neg_r ? MU_INV_NEG : MU_INV_POS);
    end

    dec_mag = {7'd0, s2_base_r} << s2_sh_r;
    if (s2_law_r == LAW_A) begin
      dec_pcm = s2_flag_r ? dec_mag : (16'd0 - dec_mag);
    end else begin
      dec_pcm = s2_flag_r ? ({7'd0, MU_DEC_BIAS} - dec_mag)
                          : (dec_mag - {7'd0, MU_DEC_BIAS});
    end

    // zero the field the operation does not produce
    out_code_nxt = (s2_mode_r == MODE_ENCODE) ? enc_code : 8'd0;
    out_pcm_nxt  = (s2_mode_r == MODE_DECODE) ? dec_pcm  : 16'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_mode_r <= s2_mode_r;
      out_code_r <= out_code_nxt;
      out_pcm_r  <= signed'(out_pcm_nxt);
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.code_out = out_code_r;
  assign out_ch.pcm_out  = out_pcm_r;

  // ------------------------------------------------------------------------
  // Assertions
  // ------------------------------------------------------------------------
  `G711_ASSERT(a_accept_enters, (in_ch.valid && in_ch.ready) |=> s1_valid_r, "accepted request lost at stage 1")
  `G711_ASSERT(a_enc_pcm_zero, (out_valid_r && out_mode_r == MODE_ENCODE) |-> (out_pcm_r == 16'sd0), "encode result carries a sample")
  `G711_ASSERT(a_dec_code_zero, (out_valid_r && out_mode_r == MODE_DECODE) |-> (out_code_r == 8'd0), "decode result carries a code")
  `G711_ASSERT(a_stall_holds_s2, (s2_valid_r && !adv) |=> s2_valid_r, "stage 2 request dropped during stall")
  `G711_ASSERT_ALWAYS(a_reset_clears, !rst_n |=> (!out_valid_r && !s1_valid_r && !s2_valid_r), "valid bits not cleared by reset")

endmodule

`default_nettype wire
